// ===== hw/rtl/abn_pkg.sv =====
// Shared constants, types and state encodings of the adaptive breath normalizer.
package abn_pkg;

  // Fixed-point formats.
  localparam int SAMPLE_FRAC_BITS = 12;
  localparam int STATE_FRAC_BITS  = 28;
  localparam int UP_SHIFT         = STATE_FRAC_BITS - SAMPLE_FRAC_BITS;
  localparam int SAMPLE_W         = SAMPLE_FRAC_BITS + 4;
  localparam int REG_W            = SAMPLE_W - 1;
  localparam int ACC_W            = STATE_FRAC_BITS + 4;
  localparam int DELTA_W          = ACC_W + 1;
  localparam int LEVEL_FRAC_BITS  = 22;
  localparam int LEVEL_W          = LEVEL_FRAC_BITS + 2;
  localparam int OUT_LEVEL_W      = 16;
  localparam int OUT_LEVEL_SHIFT  = LEVEL_FRAC_BITS - (OUT_LEVEL_W - 2);

  // Level limits of plus and minus one.
  localparam logic signed [LEVEL_W-1:0] LEVEL_POS = $signed({2'b01, {LEVEL_FRAC_BITS{1'b0}}});
  localparam logic signed [LEVEL_W-1:0] LEVEL_NEG = $signed({2'b11, {LEVEL_FRAC_BITS{1'b0}}});

  // Gain multiplier: Q0.16 gains, consumed one 4-bit digit per cycle.
  localparam int GAIN_W     = 16;
  localparam int DIGIT_W    = 4;
  localparam int NUM_DIGITS = GAIN_W / DIGIT_W;
  localparam int MUL_CNT_W  = $clog2(NUM_DIGITS);
  localparam int PROD_W     = DELTA_W + GAIN_W;
  localparam logic [GAIN_W-1:0] GAIN_CENTER   = 16'd262;
  localparam logic [GAIN_W-1:0] GAIN_ENVELOPE = 16'd1638;
  localparam logic [GAIN_W-1:0] GAIN_LEVEL    = 16'd10486;
  localparam logic signed [PROD_W-1:0] ROUND_BIAS = $signed(PROD_W'(1) << (GAIN_W - 1));

  // Ratio divider: numerator is 10 * |deviation|, denominator 22 * envelope.
  localparam int NUM_W      = ACC_W + 4;
  localparam int DEN_W      = ACC_W + 5;
  localparam int Q_W        = LEVEL_FRAC_BITS;
  localparam int TMAG_W     = Q_W + 1;
  localparam int DIV_ITERS  = Q_W / 2;
  localparam int DIV_CNT_W  = $clog2(DIV_ITERS);
  localparam logic [TMAG_W-1:0] TMAG_ONE = {1'b1, {Q_W{1'b0}}};

  // Configuration registers.
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_AMP_FLOOR = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_INIT_AMP  = 1'b1;
  localparam logic [REG_W-1:0] AMP_FLOOR_RESET   = 15'd82;
  localparam logic [REG_W-1:0] INIT_AMP_RESET    = 15'd328;

  // Main sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DELTA,
    ST_MUL_C,
    ST_MUL_E,
    ST_DIV_GO,
    ST_DIV,
    ST_MUL_L,
    ST_DONE
  } abn_state_t;

  // Divider states.
  typedef enum logic [1:0] {
    DV_IDLE,
    DV_CHECK,
    DV_RUN
  } abn_div_state_t;

  // Gain multiplier request and response.
  typedef struct packed {
    logic                      start;
    logic [GAIN_W-1:0]         gain;
    logic signed [DELTA_W-1:0] x;
  } abn_mul_req_t;

  typedef struct packed {
    logic                      done;
    logic signed [DELTA_W-1:0] res;
  } abn_mul_rsp_t;

  // Divider request and response.
  typedef struct packed {
    logic             start;
    logic [ACC_W-1:0] mag;
    logic [ACC_W-1:0] env;
  } abn_div_req_t;

  typedef struct packed {
    logic              done;
    logic [TMAG_W-1:0] tmag;
  } abn_div_rsp_t;

endpackage

// ===== hw/rtl/abn_gain_mul.sv =====
// Digit-serial constant-gain multiplier with round-to-nearest and a 16-bit right shift.
module abn_gain_mul (
  input  logic                 clk,
  input  logic                 rst_n,
  input  abn_pkg::abn_mul_req_t req,
  output abn_pkg::abn_mul_rsp_t rsp
);

  logic                                busy_r, busy_nxt;
  logic                                done_r, done_nxt;
  logic [abn_pkg::MUL_CNT_W-1:0]       cnt_r, cnt_nxt;
  logic [abn_pkg::GAIN_W-1:0]          gain_r, gain_nxt;
  logic signed [abn_pkg::DELTA_W-1:0]  x_r, x_nxt;
  logic signed [abn_pkg::PROD_W-1:0]   acc_r, acc_nxt;
  logic [abn_pkg::DIGIT_W-1:0]         digit;
  logic signed [abn_pkg::PROD_W-1:0]   x_ext;
  logic signed [abn_pkg::PROD_W-1:0]   part;
  logic                                last;

  // One gain digit per cycle, most significant first: acc = acc * 16 + x * digit.
  always_comb begin
    digit = gain_r[abn_pkg::GAIN_W-1 -: abn_pkg::DIGIT_W];
    x_ext = $signed({{(abn_pkg::PROD_W - abn_pkg::DELTA_W){x_r[abn_pkg::DELTA_W-1]}}, x_r});
    part  = '0;
    for (int i = 0; i < abn_pkg::DIGIT_W; i++) begin
      if (digit[i]) begin
        part = part + (x_ext <<< i);
      end
    end
    last = (cnt_r == abn_pkg::MUL_CNT_W'(abn_pkg::NUM_DIGITS - 1));

    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    gain_nxt = gain_r;
    x_nxt    = x_r;
    acc_nxt  = acc_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      gain_nxt = req.gain;
      x_nxt    = req.x;
      acc_nxt  = '0;
    end else if (busy_r) begin
      // The rounding half is added with the final digit.
      acc_nxt  = (acc_r <<< abn_pkg::DIGIT_W) + part + (last ? abn_pkg::ROUND_BIAS : '0);
      gain_nxt = gain_r << abn_pkg::DIGIT_W;
      cnt_nxt  = cnt_r + 1'b1;
      if (last) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // Operand shift register and accumulator.
  always_ff @(posedge clk) begin
    gain_r <= gain_nxt;
    x_r    <= x_nxt;
    acc_r  <= acc_nxt;
  end

  // The product shifted right by 16 and rounded to nearest; its magnitude never exceeds that of x.
  assign rsp.done = done_r;
  assign rsp.res  = acc_r[abn_pkg::PROD_W-1 -: abn_pkg::DELTA_W];

endmodule

// ===== hw/rtl/abn_ratio_div.sv =====
// Radix-4 restoring divider that forms |deviation| / (2.2 * envelope) clamped to one, Q1.22.
module abn_ratio_div (
  input  logic                 clk,
  input  logic                 rst_n,
  input  abn_pkg::abn_div_req_t req,
  output abn_pkg::abn_div_rsp_t rsp
);

  abn_pkg::abn_div_state_t         state_r, state_nxt;
  logic [abn_pkg::DEN_W-1:0]       rem_r, rem_nxt;
  logic [abn_pkg::DEN_W-1:0]       den_r, den_nxt;
  logic [abn_pkg::Q_W-1:0]         q_r, q_nxt;
  logic [abn_pkg::TMAG_W-1:0]      tmag_r, tmag_nxt;
  logic [abn_pkg::DIV_CNT_W-1:0]   cnt_r, cnt_nxt;
  logic                            done_r, done_nxt;
  logic [abn_pkg::DEN_W:0]         t1, t2;
  logic [abn_pkg::DEN_W-1:0]       r1, r2;
  logic                            ge1, ge2;

  always_comb begin
    // Two restoring steps per cycle.
    t1  = {rem_r, 1'b0};
    ge1 = (t1 >= {1'b0, den_r});
    r1  = ge1 ? abn_pkg::DEN_W'(t1 - {1'b0, den_r}) : t1[abn_pkg::DEN_W-1:0];
    t2  = {r1, 1'b0};
    ge2 = (t2 >= {1'b0, den_r});
    r2  = ge2 ? abn_pkg::DEN_W'(t2 - {1'b0, den_r}) : t2[abn_pkg::DEN_W-1:0];

    state_nxt = state_r;
    rem_nxt   = rem_r;
    den_nxt   = den_r;
    q_nxt     = q_r;
    tmag_nxt  = tmag_r;
    cnt_nxt   = cnt_r;
    done_nxt  = 1'b0;

    case (state_r)
      abn_pkg::DV_IDLE: begin
        // Scale both sides by ten so that the ratio 2.2 stays exact.
        if (req.start) begin
          rem_nxt   = abn_pkg::DEN_W'({req.mag, 3'b000}) + abn_pkg::DEN_W'({req.mag, 1'b0});
          den_nxt   = abn_pkg::DEN_W'({req.env, 4'b0000}) + abn_pkg::DEN_W'({req.env, 2'b00})
                      + abn_pkg::DEN_W'({req.env, 1'b0});
          state_nxt = abn_pkg::DV_CHECK;
        end
      end
      abn_pkg::DV_CHECK: begin
        // A zero deviation gives zero; a ratio of one or more clamps to one.
        if (rem_r == '0) begin
          tmag_nxt  = '0;
          done_nxt  = 1'b1;
          state_nxt = abn_pkg::DV_IDLE;
        end else if (rem_r >= den_r) begin
          tmag_nxt  = abn_pkg::TMAG_ONE;
          done_nxt  = 1'b1;
          state_nxt = abn_pkg::DV_IDLE;
        end else begin
          q_nxt     = '0;
          cnt_nxt   = '0;
          state_nxt = abn_pkg::DV_RUN;
        end
      end
      abn_pkg::DV_RUN: begin
        rem_nxt = r2;
        q_nxt   = {q_r[abn_pkg::Q_W-3:0], ge1, ge2};
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == abn_pkg::DIV_CNT_W'(abn_pkg::DIV_ITERS - 1)) begin
          tmag_nxt  = {1'b0, q_nxt};
          done_nxt  = 1'b1;
          state_nxt = abn_pkg::DV_IDLE;
        end
      end
      default: begin
        state_nxt = abn_pkg::DV_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= abn_pkg::DV_IDLE;
      done_r  <= 1'b0;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      done_r  <= done_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // Remainder, divisor and quotient shift register.
  always_ff @(posedge clk) begin
    rem_r  <= rem_nxt;
    den_r  <= den_nxt;
    q_r    <= q_nxt;
    tmag_r <= tmag_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.tmag = tmag_r;

  // A new division starts only when the previous one has finished.
  assert property (@(posedge clk) disable iff (!rst_n) req.start |-> state_r == abn_pkg::DV_IDLE)
    else $error("divider started while busy");

  // Completion is a single-cycle pulse.
  assert property (@(posedge clk) disable iff (!rst_n) done_r |=> !done_r)
    else $error("divider done held for more than one cycle");

  // The target magnitude never exceeds one.
  assert property (@(posedge clk) disable iff (!rst_n) done_r |-> tmag_r <= abn_pkg::TMAG_ONE)
    else $error("divider result above one");

endmodule

// ===== hw/rtl/adaptive_breath_normalizer.sv =====
// Top level of the adaptive breath normalizer: sequencer, filter state and channels.
//
// Usage:
//   Input channel (in_valid/in_ready): one request carries a Q4.12 sample and a
//   fresh flag. A stale request (in_fresh low) leaves the filter untouched and
//   reports the current state. The first fresh request primes the filter.
//   Result channel (out_valid/out_ready): exactly one result per request, in
//   order: the Q2.14 level, the Q4.12 center, the Q3.12 envelope, and the primed flag.
//   Configuration channel (cfg_valid/cfg_ready, always ready): index 0 writes
//   the envelope floor, index 1 the priming envelope; write only while idle.
// Timing:
//   A stale request goes straight to the final state. A fresh request takes
//   longer when the ratio is neither zero nor clamped; most of its time is
//   spent in the three passes through the digit-serial gain multiplier and
//   the 11 two-bit steps of the ratio divider.
//   One request is processed at a time; the next is taken right after the
//   result is registered.
// Reset and stalls:
//   Reset clears the filter state and restores the register defaults. A
//   result held by out_ready low lets the next request finish its computation,
//   and it waits in the final state until the output register is free.
module adaptive_breath_normalizer (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic signed [abn_pkg::SAMPLE_W-1:0]  in_sample,
  input  logic                                 in_fresh,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [abn_pkg::OUT_LEVEL_W-1:0] out_breath_level,
  output logic signed [abn_pkg::SAMPLE_W-1:0]  out_tracked_center,
  output logic [abn_pkg::REG_W-1:0]            out_tracked_amplitude,
  output logic                                 out_primed,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [abn_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [abn_pkg::REG_W-1:0]            cfg_data
);

  abn_pkg::abn_state_t                   state_r, state_nxt;
  logic [abn_pkg::REG_W-1:0]             floor_r, floor_nxt;
  logic [abn_pkg::REG_W-1:0]             init_r, init_nxt;
  logic                                  primed_r, primed_nxt;
  logic signed [abn_pkg::ACC_W-1:0]      center_r, center_nxt;
  logic [abn_pkg::ACC_W-1:0]             env_r, env_nxt;
  logic signed [abn_pkg::LEVEL_W-1:0]    level_r, level_nxt;
  logic signed [abn_pkg::SAMPLE_W-1:0]   sample_r, sample_nxt;
  logic signed [abn_pkg::DELTA_W-1:0]    delta_r, delta_nxt;
  logic [abn_pkg::ACC_W-1:0]             mag_r, mag_nxt;
  logic                                  out_valid_r, out_valid_nxt;
  logic signed [abn_pkg::OUT_LEVEL_W-1:0] out_level_r, out_level_nxt;
  logic signed [abn_pkg::SAMPLE_W-1:0]   out_center_r, out_center_nxt;
  logic [abn_pkg::REG_W-1:0]             out_amp_r, out_amp_nxt;
  logic                                  out_primed_r, out_primed_nxt;

  abn_pkg::abn_mul_req_t                 mul_req;
  abn_pkg::abn_mul_rsp_t                 mul_rsp;
  abn_pkg::abn_div_req_t                 div_req;
  abn_pkg::abn_div_rsp_t                 div_rsp;

  logic                                  in_accept;
  logic                                  out_free;
  logic signed [abn_pkg::ACC_W-1:0]      sample_state;
  logic signed [abn_pkg::DELTA_W-1:0]    delta_cmb;
  logic signed [abn_pkg::DELTA_W-1:0]    env_diff;
  logic signed [abn_pkg::DELTA_W-1:0]    center_sum;
  logic signed [abn_pkg::DELTA_W:0]      env_sum;
  logic [abn_pkg::ACC_W-1:0]             env_sat;
  logic [abn_pkg::ACC_W-1:0]             floor_state;
  logic signed [abn_pkg::LEVEL_W-1:0]    target;
  logic signed [abn_pkg::LEVEL_W:0]      level_diff;
  logic signed [abn_pkg::LEVEL_W:0]      level_sum;

  abn_gain_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mul_req),
    .rsp   (mul_rsp)
  );

  abn_ratio_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // Datapath terms shared by the sequencer.
  always_comb begin
    sample_state = $signed({sample_r, {abn_pkg::UP_SHIFT{1'b0}}});
    delta_cmb    = $signed({sample_state[abn_pkg::ACC_W-1], sample_state})
                   - $signed({center_r[abn_pkg::ACC_W-1], center_r});
    env_diff     = $signed({1'b0, mag_r}) - $signed({1'b0, env_r});
    center_sum   = $signed({center_r[abn_pkg::ACC_W-1], center_r}) + mul_rsp.res;
    env_sum      = $signed({2'b00, env_r})
                   + $signed({mul_rsp.res[abn_pkg::DELTA_W-1], mul_rsp.res});

    // Saturate the envelope at zero and at full scale; it is later held at or above the floor.
    if (env_sum[abn_pkg::DELTA_W]) begin
      env_sat = '0;
    end else if (env_sum[abn_pkg::DELTA_W-1]) begin
      env_sat = '1;
    end else begin
      env_sat = env_sum[abn_pkg::ACC_W-1:0];
    end
    floor_state = abn_pkg::ACC_W'({floor_r, {abn_pkg::UP_SHIFT{1'b0}}});

    // Signed target and the step toward it.
    if (delta_r[abn_pkg::DELTA_W-1]) begin
      target = -$signed({1'b0, div_rsp.tmag});
    end else begin
      target = $signed({1'b0, div_rsp.tmag});
    end
    level_diff = $signed({target[abn_pkg::LEVEL_W-1], target})
                 - $signed({level_r[abn_pkg::LEVEL_W-1], level_r});
    level_sum  = $signed({level_r[abn_pkg::LEVEL_W-1], level_r})
                 + $signed(mul_rsp.res[abn_pkg::LEVEL_W:0]);
  end

  // Sequencer: next state, handshakes and register updates.
  always_comb begin
    in_ready  = (state_r == abn_pkg::ST_IDLE);
    in_accept = in_valid && in_ready;
    out_free  = !out_valid_r || out_ready;

    state_nxt      = state_r;
    floor_nxt      = floor_r;
    init_nxt       = init_r;
    primed_nxt     = primed_r;
    center_nxt     = center_r;
    env_nxt        = env_r;
    level_nxt      = level_r;
    sample_nxt     = sample_r;
    delta_nxt      = delta_r;
    mag_nxt        = mag_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_level_nxt  = out_level_r;
    out_center_nxt = out_center_r;
    out_amp_nxt    = out_amp_r;
    out_primed_nxt = out_primed_r;
    mul_req.start  = 1'b0;
    mul_req.gain   = abn_pkg::GAIN_CENTER;
    mul_req.x      = delta_cmb;
    div_req.start  = 1'b0;
    div_req.mag    = mag_r;
    div_req.env    = env_r;

    // Register writes must arrive only while the block is idle; the block itself does not enforce this.
    if (cfg_valid) begin
      case (cfg_index)
        abn_pkg::CFG_AMP_FLOOR: floor_nxt = cfg_data;
        abn_pkg::CFG_INIT_AMP:  init_nxt  = cfg_data;
        default: begin
        end
      endcase
    end

    case (state_r)
      abn_pkg::ST_IDLE: begin
        if (in_accept) begin
          sample_nxt = in_sample;
          if (in_fresh) begin
            // The first fresh request primes the filter.
            if (!primed_r) begin
              primed_nxt = 1'b1;
              center_nxt = $signed({in_sample, {abn_pkg::UP_SHIFT{1'b0}}});
              env_nxt    = abn_pkg::ACC_W'({init_r, {abn_pkg::UP_SHIFT{1'b0}}});
              level_nxt  = '0;
            end
            state_nxt = abn_pkg::ST_DELTA;
          end else begin
            state_nxt = abn_pkg::ST_DONE;
          end
        end
      end
      abn_pkg::ST_DELTA: begin
        // Deviation from the center; the center update starts right away.
        delta_nxt     = delta_cmb;
        mag_nxt       = delta_cmb[abn_pkg::DELTA_W-1] ?
                        abn_pkg::ACC_W'(-delta_cmb) : delta_cmb[abn_pkg::ACC_W-1:0];
        mul_req.start = 1'b1;
        state_nxt     = abn_pkg::ST_MUL_C;
      end
      abn_pkg::ST_MUL_C: begin
        mul_req.gain = abn_pkg::GAIN_ENVELOPE;
        mul_req.x    = env_diff;
        if (mul_rsp.done) begin
          center_nxt    = center_sum[abn_pkg::ACC_W-1:0];
          mul_req.start = 1'b1;
          state_nxt     = abn_pkg::ST_MUL_E;
        end
      end
      abn_pkg::ST_MUL_E: begin
        if (mul_rsp.done) begin
          env_nxt   = (env_sat < floor_state) ? floor_state : env_sat;
          state_nxt = abn_pkg::ST_DIV_GO;
        end
      end
      abn_pkg::ST_DIV_GO: begin
        div_req.start = 1'b1;
        state_nxt     = abn_pkg::ST_DIV;
      end
      abn_pkg::ST_DIV: begin
        mul_req.gain = abn_pkg::GAIN_LEVEL;
        mul_req.x    = $signed({{(abn_pkg::DELTA_W - abn_pkg::LEVEL_W - 1)
                                 {level_diff[abn_pkg::LEVEL_W]}}, level_diff});
        if (div_rsp.done) begin
          mul_req.start = 1'b1;
          state_nxt     = abn_pkg::ST_MUL_L;
        end
      end
      abn_pkg::ST_MUL_L: begin
        if (mul_rsp.done) begin
          level_nxt = level_sum[abn_pkg::LEVEL_W-1:0];
          state_nxt = abn_pkg::ST_DONE;
        end
      end
      abn_pkg::ST_DONE: begin
        // Publish the state once the output register is free.
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_level_nxt  = level_r[abn_pkg::OUT_LEVEL_SHIFT +: abn_pkg::OUT_LEVEL_W];
          out_center_nxt = center_r[abn_pkg::UP_SHIFT +: abn_pkg::SAMPLE_W];
          out_amp_nxt    = env_r[abn_pkg::ACC_W-1] ? '1 : env_r[abn_pkg::UP_SHIFT +: abn_pkg::REG_W];
          out_primed_nxt = primed_r;
          state_nxt      = abn_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = abn_pkg::ST_IDLE;
      end
    endcase
  end

  // Control state, filter state and configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= abn_pkg::ST_IDLE;
      floor_r     <= abn_pkg::AMP_FLOOR_RESET;
      init_r      <= abn_pkg::INIT_AMP_RESET;
      primed_r    <= 1'b0;
      center_r    <= '0;
      env_r       <= '0;
      level_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      floor_r     <= floor_nxt;
      init_r      <= init_nxt;
      primed_r    <= primed_nxt;
      center_r    <= center_nxt;
      env_r       <= env_nxt;
      level_r     <= level_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Working and output payload registers.
  always_ff @(posedge clk) begin
    sample_r     <= sample_nxt;
    delta_r      <= delta_nxt;
    mag_r        <= mag_nxt;
    out_level_r  <= out_level_nxt;
    out_center_r <= out_center_nxt;
    out_amp_r    <= out_amp_nxt;
    out_primed_r <= out_primed_nxt;
  end

  assign cfg_ready             = 1'b1;
  assign out_valid             = out_valid_r;
  assign out_breath_level      = out_level_r;
  assign out_tracked_center    = out_center_r;
  assign out_tracked_amplitude = out_amp_r;
  assign out_primed            = out_primed_r;

  // Only one request is in work at a time.
  assert property (@(posedge clk) disable iff (!rst_n) in_valid && in_ready |=> !in_ready)
    else $error("request accepted while another is in work");

  // Once primed, the filter stays primed until reset.
  assert property (@(posedge clk) disable iff (!rst_n)
                   $past(rst_n) && $past(primed_r) |-> primed_r)
    else $error("primed flag dropped without reset");

  // The smoothed level never leaves the range from minus one to plus one.
  assert property (@(posedge clk) disable iff (!rst_n)
                   level_r <= abn_pkg::LEVEL_POS && level_r >= abn_pkg::LEVEL_NEG)
    else $error("level out of range");

endmodule
